@@ rtl/fosm_pkg.sv @@
// ----------------------------------------------------------------------------
// fosm_pkg: object sector map shared definitions
// widths, request and status codes, register indexes and the command and
// status bundles that join the controller to the datapath
// ----------------------------------------------------------------------------
package fosm_pkg;

	// directory geometry
	localparam int MAX_ENTRIES  = 256;
	localparam int IDX_W        = $clog2(MAX_ENTRIES);
	localparam int CNT_W        = IDX_W + 1;
	localparam int HEADER_BYTES = 16;
	localparam int HDR_SHIFT    = $clog2(HEADER_BYTES);

	// field widths
	localparam int REQ_W  = 2;
	localparam int OBJ_W  = 32;
	localparam int INST_W = 16;
	localparam int STAT_W = 3;
	localparam int ADDR_W = 24;
	localparam int SIZE_W = 17;
	localparam int CHIP_W = 25;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;

	// internal arithmetic widths
	localparam int HDR_W  = ADDR_W + 1;
	localparam int PROD_W = SIZE_W + CNT_W;
	localparam int SEC_W  = PROD_W + 1;
	localparam int LIM_W  = SEC_W + 1;
	localparam int ENT_W  = OBJ_W + INST_W + ADDR_W;

	// sector addresses are 24-bit, so nothing may reach past this
	localparam logic [CHIP_W-1:0] ADDR_SPACE = CHIP_W'(1) << ADDR_W;

	// reset values of the registers
	localparam logic [ADDR_W-1:0] TABLE_START_RST = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] TABLE_END_RST   = ADDR_W'(4096);
	localparam logic [SIZE_W-1:0] SEC_BYTES_RST   = SIZE_W'(4096);
	localparam logic [CHIP_W-1:0] CHIP_SIZE_RST   = CHIP_W'(1048576);

	typedef enum logic [REQ_W-1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_SAVE   = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		ST_FOUND   = 3'd0,
		ST_ALLOC   = 3'd1,
		ST_MISS    = 3'd2,
		ST_FULL    = 3'd3,
		ST_BEYOND  = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TABLE_START = 2'd0,
		CFG_TABLE_END   = 2'd1,
		CFG_SEC_BYTES   = 2'd2,
		CFG_CHIP_SIZE   = 2'd3
	} cfg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    scan;
		logic    alloc;
		logic    clear;
		logic    res_we;
		status_t res_code;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic scan_done;
		logic full;
		logic beyond;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/fosm_if.sv @@
// ----------------------------------------------------------------------------
// fosm_if: request and response channels of the object sector map
// valid/ready channels; a beat moves at a clock edge with valid and ready high
// ----------------------------------------------------------------------------
interface fosm_req_if import fosm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [OBJ_W-1:0]  obj_id;
	logic [INST_W-1:0] inst_id;

	modport source (output valid, req_type, obj_id, inst_id, input ready);
	modport sink (input valid, req_type, obj_id, inst_id, output ready);
endinterface

interface fosm_rsp_if import fosm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [ADDR_W-1:0] sector_addr;

	modport source (output valid, status, sector_addr, input ready);
	modport sink (input valid, status, sector_addr, output ready);
endinterface

@@ rtl/flash_object_sector_map.sv @@
// ----------------------------------------------------------------------------
// flash_object_sector_map: object to flash sector directory
// append-only directory of (object id, instance id) pairs, each owning one
// data sector; lookup, save (lookup or allocate) and clear requests
// ----------------------------------------------------------------------------
// one request is handled at a time. a request is taken only while the block
// is idle, then the directory is scanned from the first entry, one entry per
// clock out of the single-port directory memory, until the first match or the
// scan bound (entry count, or a header that would start at or past the table
// end). a save that misses then goes through a check state and a decide
// state before its response. a clear, or an unused request code, goes
// straight to the response without a scan. the response sits in an output
// register, so a held response only stalls the block once the next one is
// ready. an allocated sector lies at table_end + sector bytes * index and
// the address is stored with the entry, so later register writes do not
// move existing sectors. registers should be written only while no request
// is in flight. the directory memory needs no clearing after reset: only
// entries below the entry count are ever read.
// ----------------------------------------------------------------------------
module flash_object_sector_map import fosm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	fosm_req_if.sink              req,
	fosm_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// command and status bundles between controller and datapath
	cmd_t  cmd;
	stat_t st;

	// controller: accept, scan, decide, respond
	fosm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// datapath: registers, directory memory and response register
	fosm_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.obj_id     (req.obj_id),
		.inst_id    (req.inst_id),
		.cmd        (cmd),
		.st         (st),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.rsp_status (rsp.status),
		.rsp_addr   (rsp.sector_addr)
	);

endmodule

@@ rtl/fosm_dpath.sv @@
// ----------------------------------------------------------------------------
// fosm_dpath: object sector map datapath
// registers, directory memory, scan pointer, allocation arithmetic and the
// response register
// ----------------------------------------------------------------------------
module fosm_dpath import fosm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [OBJ_W-1:0]      obj_id,
	input  logic [INST_W-1:0]     inst_id,
	input  cmd_t                  cmd,
	output stat_t                 st,
	input  logic                  rsp_ready,
	output logic                  rsp_valid,
	output logic [STAT_W-1:0]     rsp_status,
	output logic [ADDR_W-1:0]     rsp_addr
);

	logic [ADDR_W-1:0] table_start_q;
	logic [ADDR_W-1:0] table_end_q;
	logic [SIZE_W-1:0] sec_bytes_q;
	logic [CHIP_W-1:0] chip_size_q;

	logic [ENT_W-1:0]  mem_q [MAX_ENTRIES];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [HDR_W-1:0]  hdr_q;
	logic              vld_s1;
	logic [ENT_W-1:0]  ent_s1;
	logic [OBJ_W-1:0]  obj_q;
	logic [INST_W-1:0] inst_q;
	logic [PROD_W-1:0] prod_q;
	logic [SEC_W-1:0]  sec_q;
	logic              rsp_valid_q;
	logic [STAT_W-1:0] rsp_status_q;
	logic [ADDR_W-1:0] rsp_addr_q;

	logic              more;
	logic              match;
	logic              advance;
	logic              issue;
	logic [HDR_W-1:0]  hdr_next_end;
	logic [CHIP_W-1:0] limit;
	logic [LIM_W-1:0]  sec_end;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_start_q <= TABLE_START_RST;
			table_end_q   <= TABLE_END_RST;
			sec_bytes_q   <= SEC_BYTES_RST;
			chip_size_q   <= CHIP_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_TABLE_START: table_start_q <= cfg_data[ADDR_W-1:0];
				CFG_TABLE_END:   table_end_q   <= cfg_data[ADDR_W-1:0];
				CFG_SEC_BYTES:   sec_bytes_q   <= cfg_data[SIZE_W-1:0];
				CFG_CHIP_SIZE:   chip_size_q   <= cfg_data[CHIP_W-1:0];
				default: ;
			endcase
		end
	end

	// scan bound: entry below count and header below table end
	assign more    = (idx_q < count_q) && (hdr_q < HDR_W'(table_end_q));
	assign match   = vld_s1 && (ent_s1[ENT_W-1 -: OBJ_W] == obj_q)
	                 && (ent_s1[ADDR_W +: INST_W] == inst_q);
	assign advance = cmd.scan && !match;
	assign issue   = advance && more;

	// allocation checks
	assign hdr_next_end = HDR_W'(table_start_q)
	                      + (HDR_W'(count_q + CNT_W'(1)) << HDR_SHIFT);
	assign limit   = (chip_size_q > ADDR_SPACE) ? ADDR_SPACE : chip_size_q;
	assign sec_end = LIM_W'(sec_q) + LIM_W'(sec_bytes_q);

	assign st.hit       = match;
	assign st.scan_done = !more && !vld_s1;
	assign st.full      = (count_q >= CNT_W'(MAX_ENTRIES))
	                      || (hdr_next_end > HDR_W'(table_end_q));
	assign st.beyond    = sec_end > LIM_W'(limit);
	assign st.out_free  = !rsp_valid_q || rsp_ready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			hdr_q       <= '0;
			vld_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q  <= '0;
				hdr_q  <= HDR_W'(table_start_q);
				vld_s1 <= 1'b0;
			end else if (advance) begin
				vld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
					hdr_q <= hdr_q + HDR_W'(HEADER_BYTES);
				end
			end
			if (cmd.clear)
				count_q <= '0;
			else if (cmd.alloc)
				count_q <= count_q + CNT_W'(1);
			if (cmd.res_we)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// payload: request, memory, arithmetic pipeline, response
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			obj_q  <= obj_id;
			inst_q <= inst_id;
		end
		if (issue)
			ent_s1 <= mem_q[idx_q[IDX_W-1:0]];
		if (cmd.alloc)
			mem_q[count_q[IDX_W-1:0]] <= {obj_q, inst_q, sec_q[ADDR_W-1:0]};
		prod_q <= PROD_W'(sec_bytes_q) * PROD_W'(count_q);
		sec_q  <= SEC_W'(table_end_q) + SEC_W'(prod_q);
		if (cmd.res_we) begin
			rsp_status_q <= cmd.res_code;
			case (cmd.res_code)
				ST_FOUND: rsp_addr_q <= ent_s1[ADDR_W-1:0];
				ST_ALLOC: rsp_addr_q <= sec_q[ADDR_W-1:0];
				default:  rsp_addr_q <= '0;
			endcase
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign rsp_status = rsp_status_q;
	assign rsp_addr   = rsp_addr_q;

endmodule

@@ rtl/fosm_ctrl.sv @@
// ----------------------------------------------------------------------------
// fosm_ctrl: object sector map controller
// sequences accept, directory scan, allocation decision and response
// ----------------------------------------------------------------------------
module fosm_ctrl import fosm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [REQ_W-1:0] req_type,
	output logic             req_ready,
	input  stat_t            st,
	output cmd_t             cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CHECK,
		S_DECIDE,
		S_FINISH
	} state_t;

	state_t  state_q;
	status_t code_q;
	logic    save_q;
	logic    alloc_q;
	logic    clear_q;

	assign req_ready    = (state_q == S_IDLE);
	assign cmd.load     = req_valid && req_ready;
	assign cmd.scan     = (state_q == S_SCAN);
	assign cmd.res_we   = (state_q == S_FINISH) && st.out_free;
	assign cmd.alloc    = cmd.res_we && alloc_q;
	assign cmd.clear    = cmd.res_we && clear_q;
	assign cmd.res_code = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_MISS;
			save_q  <= 1'b0;
			alloc_q <= 1'b0;
			clear_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						save_q  <= (req_type_t'(req_type) == REQ_SAVE);
						alloc_q <= 1'b0;
						clear_q <= 1'b0;
						case (req_type_t'(req_type))
							REQ_LOOKUP, REQ_SAVE: state_q <= S_SCAN;
							REQ_CLEAR: begin
								code_q  <= ST_CLEARED;
								clear_q <= 1'b1;
								state_q <= S_FINISH;
							end
							default: begin
								code_q  <= ST_MISS;
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (st.hit) begin
						code_q  <= ST_FOUND;
						state_q <= S_FINISH;
					end else if (st.scan_done) begin
						if (save_q)
							state_q <= S_CHECK;
						else begin
							code_q  <= ST_MISS;
							state_q <= S_FINISH;
						end
					end
				end
				// sector arithmetic settles
				S_CHECK: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (st.full)
						code_q <= ST_FULL;
					else if (st.beyond)
						code_q <= ST_BEYOND;
					else begin
						code_q  <= ST_ALLOC;
						alloc_q <= 1'b1;
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (st.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/fosm_checker.sv @@
// ----------------------------------------------------------------------------
// fosm_checker: port level checks for the object sector map
// watches the request and response channels of the top level
// ----------------------------------------------------------------------------
module fosm_checker import fosm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [STAT_W-1:0] rsp_status,
	input logic [ADDR_W-1:0] rsp_addr
);

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_addr))
		else $error("response changed while stalled");

	// a response beat leaves only when taken
	a_rsp_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rsp_valid) |-> $past(rsp_ready))
		else $error("response dropped without handshake");

	// only found and allocated carry an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_FOUND) && (rsp_status != ST_ALLOC)
		|-> (rsp_addr == '0))
		else $error("address on an error or clear response");

	// one request at a time: busy after a request beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

endmodule

bind flash_object_sector_map fosm_checker u_fosm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_addr   (rsp.sector_addr)
);

@@ tb/tb_flash_object_sector_map.sv @@
// ----------------------------------------------------------------------------
// tb_flash_object_sector_map: self-checking bench for the object sector map
// drives lookup, save, clear and unused requests under many register settings,
// predicts every response from a shadow copy of the directory and compares
// each response beat field by field, with random gaps on both channels
// ----------------------------------------------------------------------------
module tb_flash_object_sector_map;
	import fosm_pkg::*;

	// no-progress limit, well above one full scan plus the longest gap or stall
	localparam int IDLE_LIMIT   = 4000;
	// quiet time after the last response, to catch strays
	localparam int SETTLE_CYC   = 300;
	localparam int RANDOM_ITEMS = 2000;
	localparam int POOL_MAX     = 32;

	typedef struct packed {
		req_type_t         kind;
		logic [OBJ_W-1:0]  obj;
		logic [INST_W-1:0] inst;
	} map_req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] addr;
	} sector_reply_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// everything the bench drives, known from time zero
	logic                  req_valid = 1'b0;
	req_type_t             req_kind  = REQ_LOOKUP;
	logic [OBJ_W-1:0]      req_obj   = '0;
	logic [INST_W-1:0]     req_inst  = '0;
	logic                  rsp_ready = 1'b0;
	logic                  cfg_we    = 1'b0;
	cfg_idx_t              cfg_idx   = CFG_TABLE_START;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	fosm_req_if req_ch ();
	fosm_rsp_if rsp_ch ();

	assign req_ch.valid    = req_valid;
	assign req_ch.req_type = req_kind;
	assign req_ch.obj_id   = req_obj;
	assign req_ch.inst_id  = req_inst;
	assign rsp_ch.ready    = rsp_ready;

	flash_object_sector_map dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// shadow registers, starting from their reset values
	logic [ADDR_W-1:0] map_start  = TABLE_START_RST;
	logic [ADDR_W-1:0] map_end    = TABLE_END_RST;
	logic [SIZE_W-1:0] map_sector = SEC_BYTES_RST;
	logic [CHIP_W-1:0] map_chip   = CHIP_SIZE_RST;

	// shadow directory; entries at or above dir_count are never read
	logic [OBJ_W-1:0]  dir_obj    [MAX_ENTRIES];
	logic [INST_W-1:0] dir_inst   [MAX_ENTRIES];
	logic [ADDR_W-1:0] dir_sector [MAX_ENTRIES];
	int                dir_count = 0;

	// request beats still to send, and responses still owed by the block
	map_req_t      requests_waiting [$];
	sector_reply_t replies_due      [$];

	int   mismatches   = 0;
	int   quiet_cycles = 0;
	logic req_taken    = 1'b0;
	int   send_gap     = 0;
	int   sink_stall   = 0;
	logic src_idle_on  = 1'b0;
	logic snk_idle_on  = 1'b0;

	// key pool for the random part, so that saves and lookups meet again
	logic [OBJ_W-1:0]  pool_obj  [POOL_MAX];
	logic [INST_W-1:0] pool_inst [POOL_MAX];
	int                pool_n = 1;

	// ------------------------------------------------------------------------
	// predictor: applies one request to the shadow directory
	// ------------------------------------------------------------------------
	function automatic sector_reply_t map_request(map_req_t r);
		sector_reply_t res;
		int     hit;
		longint tstart, tend, ssize, chip, n, hdr_end, sec, ceiling;
		tstart     = longint'(map_start);
		tend       = longint'(map_end);
		ssize      = longint'(map_sector);
		chip       = longint'(map_chip);
		res.status = ST_MISS;
		res.addr   = '0;
		hit        = -1;
		if (r.kind == REQ_CLEAR) begin
			dir_count  = 0;
			res.status = ST_CLEARED;
		end else if (r.kind == REQ_LOOKUP || r.kind == REQ_SAVE) begin
			// first match wins; the walk stops at a header starting at or past table end
			for (int i = 0; i < dir_count; i++) begin
				if (tstart + HEADER_BYTES * i >= tend)
					break;
				if (dir_obj[i] == r.obj && dir_inst[i] == r.inst) begin
					hit = i;
					break;
				end
			end
			if (hit >= 0) begin
				res.status = ST_FOUND;
				res.addr   = dir_sector[hit];
			end else if (r.kind == REQ_SAVE) begin
				n       = longint'(dir_count);
				hdr_end = tstart + HEADER_BYTES * (n + 1);
				sec     = tend + ssize * n;
				// sectors must also stay inside the 24-bit address space
				ceiling = chip;
				if (ceiling > (longint'(1) << ADDR_W))
					ceiling = longint'(1) << ADDR_W;
				if (n >= MAX_ENTRIES || hdr_end > tend) begin
					res.status = ST_FULL;
				end else if (sec + ssize > ceiling) begin
					res.status = ST_BEYOND;
				end else begin
					dir_obj[n]    = r.obj;
					dir_inst[n]   = r.inst;
					dir_sector[n] = ADDR_W'(sec);
					dir_count++;
					res.status = ST_ALLOC;
					res.addr   = ADDR_W'(sec);
				end
			end
		end
		return res;
	endfunction

	// gap length: mostly none or short, now and then long
	function automatic int idle_len(logic enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------------
	// driver: request beats and response ready change on the falling edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		map_req_t nxt;
		if (arst_n) begin
			// a beat in flight is held until the rising edge takes it
			if (!req_valid || req_taken) begin
				req_taken = 1'b0;
				if (send_gap > 0) begin
					req_valid <= 1'b0;
					send_gap--;
				end else if (requests_waiting.size() != 0) begin
					nxt = requests_waiting.pop_front();
					req_valid <= 1'b1;
					req_kind  <= nxt.kind;
					req_obj   <= nxt.obj;
					req_inst  <= nxt.inst;
					send_gap  = idle_len(src_idle_on);
				end else begin
					req_valid <= 1'b0;
				end
			end
			// response side stalls at random, whatever the block is doing
			if (sink_stall > 0) begin
				rsp_ready <= 1'b0;
				sink_stall--;
			end else begin
				rsp_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					sink_stall = idle_len(snk_idle_on);
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: register writes, accepted requests and responses, on the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		map_req_t      beat;
		sector_reply_t due;
		logic          moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_we) begin
				moved = 1'b1;
				case (cfg_idx)
					CFG_TABLE_START: map_start  = cfg_data[ADDR_W-1:0];
					CFG_TABLE_END:   map_end    = cfg_data[ADDR_W-1:0];
					CFG_SEC_BYTES:   map_sector = cfg_data[SIZE_W-1:0];
					CFG_CHIP_SIZE:   map_chip   = cfg_data[CHIP_W-1:0];
					default: ;
				endcase
			end
			if (req_valid && req_ch.ready) begin
				moved      = 1'b1;
				req_taken  = 1'b1;
				beat.kind  = req_kind;
				beat.obj   = req_obj;
				beat.inst  = req_inst;
				replies_due.push_back(map_request(beat));
			end
			if (rsp_ch.valid && rsp_ready) begin
				moved = 1'b1;
				if (replies_due.size() == 0) begin
					$error("unexpected response beat: status %0d sector_addr 0x%06h",
						rsp_ch.status, rsp_ch.sector_addr);
					mismatches++;
				end else begin
					due = replies_due.pop_front();
					if (rsp_ch.status !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, rsp_ch.status);
						mismatches++;
					end
					if (rsp_ch.sector_addr !== due.addr) begin
						$error("sector_addr: expected 0x%06h, got 0x%06h",
							due.addr, rsp_ch.sector_addr);
						mismatches++;
					end
				end
			end
			// watchdog on cycles without any beat or register write
			if (moved)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("FAIL flash_object_sector_map");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_req(req_type_t k, logic [OBJ_W-1:0] o, logic [INST_W-1:0] i);
		map_req_t item;
		item.kind = k;
		item.obj  = o;
		item.inst = i;
		requests_waiting.push_back(item);
	endtask

	// waits until every queued request is sent and every owed response has come back
	task automatic drain();
		while (requests_waiting.size() != 0 || req_valid || replies_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_map(logic [ADDR_W-1:0] st, logic [ADDR_W-1:0] en,
		logic [SIZE_W-1:0] sz, logic [CHIP_W-1:0] ch);
		write_reg(CFG_TABLE_START, CFG_DATA_W'(st));
		write_reg(CFG_TABLE_END, CFG_DATA_W'(en));
		write_reg(CFG_SEC_BYTES, CFG_DATA_W'(sz));
		write_reg(CFG_CHIP_SIZE, CFG_DATA_W'(ch));
	endtask

	// random geometry: mostly sane layouts, with the extremes mixed in
	task automatic random_map();
		logic [ADDR_W-1:0] st, en;
		logic [SIZE_W-1:0] sz;
		logic [CHIP_W-1:0] ch;
		longint            lim;
		int                r;
		r = $urandom_range(0, 19);
		if (r < 8)
			st = '0;
		else if (r < 16)
			st = ADDR_W'($urandom_range(0, 4096));
		else if (r == 16)
			st = '1;
		else
			st = ADDR_W'($urandom);
		r = $urandom_range(0, 19);
		if (r == 0)
			en = '0;
		else if (r == 1)
			en = '1;
		else if (r < 5)
			en = ADDR_W'($urandom);
		else
			en = ADDR_W'(st + 16 * $urandom_range(0, 300)
				+ (($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0));
		r = $urandom_range(0, 9);
		if (r == 0)
			sz = '0;
		else if (r == 1)
			sz = SIZE_W'(1);
		else if (r == 2)
			sz = SIZE_W'(65536);
		else if (r < 7)
			sz = SIZE_W'($urandom_range(1, 4096));
		else
			sz = SIZE_W'($urandom_range(1, 65536));
		r = $urandom_range(0, 9);
		if (r == 0) begin
			ch = '0;
		end else if (r < 4) begin
			ch = ADDR_SPACE;
		end else if (r < 7) begin
			ch = CHIP_W'($urandom_range(0, 1 << ADDR_W));
		end else begin
			// room for up to 64 sectors past the table
			lim = longint'(en) + longint'(sz) * $urandom_range(1, 64);
			if (lim > (longint'(1) << ADDR_W))
				lim = longint'(1) << ADDR_W;
			ch = CHIP_W'(lim);
		end
		set_map(st, en, sz, ch);
	endtask

	// fresh key pool; some keys share an object id with another instance id
	task automatic new_pool();
		pool_n = $urandom_range(2, POOL_MAX);
		for (int k = 0; k < pool_n; k++) begin
			pool_inst[k] = INST_W'($urandom);
			if (k > 0 && $urandom_range(0, 3) == 0)
				pool_obj[k] = pool_obj[k-1];
			else
				pool_obj[k] = $urandom;
		end
	endtask

	task automatic random_item();
		int pick, sel;
		pick = $urandom_range(0, 99);
		sel  = $urandom_range(0, pool_n - 1);
		if (pick < 45)
			queue_req(REQ_SAVE, pool_obj[sel], pool_inst[sel]);
		else if (pick < 85)
			queue_req(REQ_LOOKUP, pool_obj[sel], pool_inst[sel]);
		else if (pick < 90)
			queue_req(REQ_LOOKUP, $urandom, INST_W'($urandom));
		else if (pick < 95)
			queue_req(REQ_SAVE, $urandom, INST_W'($urandom));
		else if (pick < 97)
			queue_req(REQ_CLEAR, $urandom, INST_W'($urandom));
		else
			queue_req(REQ_NONE, $urandom, INST_W'($urandom));
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		int               sent, rounds, len;
		logic [OBJ_W-1:0] deep_base;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;

		// reset geometry: hits, misses, partial matches, unused code and clear
		queue_req(REQ_LOOKUP, 32'h0, 16'h0);
		queue_req(REQ_SAVE, 32'h0, 16'h0);
		queue_req(REQ_SAVE, 32'hFFFF_FFFF, 16'hFFFF);
		queue_req(REQ_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);
		queue_req(REQ_SAVE, 32'h0, 16'h0);
		queue_req(REQ_LOOKUP, 32'h0, 16'hFFFF);
		queue_req(REQ_NONE, 32'hFFFF_FFFF, 16'hFFFF);
		queue_req(REQ_CLEAR, 32'h0, 16'h0);
		queue_req(REQ_LOOKUP, 32'h0, 16'h0);
		queue_req(REQ_SAVE, 32'hA5A5_A5A5, 16'h5A5A);

		// three-header table with a tight chip: third save lands beyond chip
		drain();
		set_map(24'd0, 24'd48, 17'd16, 25'd80);
		queue_req(REQ_CLEAR, 32'h0, 16'h0);
		queue_req(REQ_SAVE, 32'h1111_1111, 16'h0001);
		queue_req(REQ_SAVE, 32'h2222_2222, 16'h0002);
		queue_req(REQ_SAVE, 32'h3333_3333, 16'h0003);
		// larger chip: third entry fits, the fourth header overruns the table
		drain();
		write_reg(CFG_CHIP_SIZE, ADDR_SPACE);
		queue_req(REQ_SAVE, 32'h3333_3333, 16'h0003);
		queue_req(REQ_SAVE, 32'h4444_4444, 16'h0004);
		// moving the table start hides the second entry from the scan
		drain();
		write_reg(CFG_TABLE_START, CFG_DATA_W'(32));
		queue_req(REQ_LOOKUP, 32'h2222_2222, 16'h0002);
		queue_req(REQ_LOOKUP, 32'h1111_1111, 16'h0001);

		// table start and end both at the top: no room for any header
		drain();
		set_map('1, '1, '0, '0);
		queue_req(REQ_CLEAR, 32'h0, 16'h0);
		queue_req(REQ_SAVE, 32'h5555_5555, 16'h0005);

		// last byte of the address space is a legal sector, the next is not
		drain();
		set_map('0, '1, 17'd1, ADDR_SPACE);
		queue_req(REQ_SAVE, 32'h6666_6666, 16'h0006);
		queue_req(REQ_SAVE, 32'h7777_7777, 16'h0007);
		queue_req(REQ_LOOKUP, 32'h6666_6666, 16'h0006);

		// zero sector size: every new sector sits at table end
		drain();
		set_map('0, 24'd4096, '0, ADDR_SPACE);
		queue_req(REQ_SAVE, 32'h8888_8888, 16'h0008);
		queue_req(REQ_SAVE, 32'h9999_9999, 16'h0009);

		// random part in rounds; each round boundary drains the block
		new_pool();
		sent   = 0;
		rounds = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			src_idle_on = ($urandom_range(0, 3) != 0);
			snk_idle_on = ($urandom_range(0, 3) != 0);
			if (rounds == 2) begin
				// fill all entries, overflow, then scan deep into the full directory
				set_map('0, 24'd4096, 17'd1, ADDR_SPACE);
				deep_base = $urandom;
				queue_req(REQ_CLEAR, 32'h0, 16'h0);
				for (int k = 0; k < MAX_ENTRIES + 4; k++)
					queue_req(REQ_SAVE, deep_base + k, INST_W'(k));
				for (int k = 0; k < 16; k++) begin
					len = $urandom_range(0, MAX_ENTRIES + 3);
					queue_req(REQ_LOOKUP, deep_base + len, INST_W'(len));
				end
				queue_req(REQ_LOOKUP, deep_base + MAX_ENTRIES - 1, INST_W'(MAX_ENTRIES - 1));
				queue_req(REQ_SAVE, deep_base + MAX_ENTRIES - 1, INST_W'(MAX_ENTRIES - 1));
				sent += MAX_ENTRIES + 23;
			end else begin
				if ($urandom_range(0, 9) < 6)
					random_map();
				if ($urandom_range(0, 2) == 0)
					new_pool();
				len = $urandom_range(40, 160);
				repeat (len) random_item();
				sent += len;
			end
			rounds++;
		end

		drain();
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("PASS flash_object_sector_map");
		else
			$display("FAIL flash_object_sector_map");
		$finish;
	end

endmodule
